### design/nand_flash_array_model_macros.svh
// assertion macros shared by the flash array model
`ifndef NAND_FLASH_ARRAY_MODEL_MACROS_SVH
`define NAND_FLASH_ARRAY_MODEL_MACROS_SVH

// same-cycle implication, checked out of reset
`define NFA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define NFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/nfa_pkg.sv
// package with constants and types of the nand flash array model
`timescale 1ns / 1ps

package nfa_pkg;

  // width for range arithmetic, holds page_bytes << 15 without overflow
  localparam int CW = 29;

  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_PROG  = 2'd1;
  localparam logic [1:0] ACT_ERASE = 2'd2;

  localparam logic [1:0] REG_FLASH_SIZE = 2'd0;
  localparam logic [1:0] REG_LOG2_PPB   = 2'd1;
  localparam logic [1:0] REG_PAGE_BYTES = 2'd2;

  localparam logic [18:0] FLASH_SIZE_RST = 19'd262144;
  localparam logic [3:0]  LOG2_PPB_RST   = 4'd6;
  localparam logic [12:0] PAGE_BYTES_RST = 13'd2112;

  localparam logic [7:0] ERASED_BYTE = 8'hFF;

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_ERASE  = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

endpackage

### design/nand_flash_array_model.sv
// Byte-wide NAND flash array model. After reset a clearing pass writes 0xFF
// to every byte, one byte a cycle, during which no transaction is
// accepted (configuration writes still are). A read or program transaction
// reads its byte from the array in the accept cycle; the byte is written
// back ANDed with write_byte when the result goes to the output register,
// the read-modify-write going through one port pair of the array ram.
// An erase writes 0xFF to each byte of its block, page_bytes <<
// log2_pages_per_block bytes, one byte a cycle; a rejected or empty
// transaction goes from the accept straight to the result. A new one is
// taken while the previous result waits in the output register.
`timescale 1ns / 1ps
`include "nand_flash_array_model_macros.svh"

module nand_flash_array_model
  import nfa_pkg::*;
#(
  parameter int MEM_BYTES = 262144
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [18:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [19:0] start_addr,
  input  logic [18:0] length,
  input  logic [17:0] byte_index,
  input  logic [7:0]  write_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic [7:0]  read_byte
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_BYTES - 1);

  state_t state;

  logic [18:0] flash_size;
  logic [3:0]  log2_pages;
  logic [12:0] page_bytes;

  logic [AW-1:0] clear_addr;
  logic [18:0]   erase_cursor;
  logic [18:0]   erase_len;
  logic [AW-1:0] acc_addr;
  logic          op_read;
  logic          op_prog;
  logic          touch;
  logic          res_status;
  logic [7:0]    wbyte;

  logic          in_fire;
  logic          result_go;
  logic [CW-1:0] lim;
  logic [CW-1:0] nbytes;
  logic [CW-1:0] len_use;
  logic [CW-1:0] addr_sum;
  logic          is_rw;
  logic          is_erase;
  logic          bad;
  logic          in_touch;
  logic [18:0]   erase_inc;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;

  // range check of the offered transaction
  always_comb begin
    lim = (CW'(flash_size) > CW'(MEM_BYTES)) ? CW'(MEM_BYTES) : CW'(flash_size);
    nbytes = CW'(page_bytes) << log2_pages;
    is_rw = (action == ACT_READ) || (action == ACT_PROG);
    is_erase = (action == ACT_ERASE);
    len_use = is_erase ? nbytes : CW'(length);
    bad = (len_use > lim) || (CW'(start_addr) > (lim - len_use));
    in_touch = is_rw && !bad && ({1'b0, byte_index} < length);
    addr_sum = CW'(start_addr) + (is_erase ? CW'(0) : CW'(byte_index));
  end

  assign in_ready = (state == S_IDLE);
  assign in_fire = in_valid && in_ready;
  assign result_go = (state == S_RESULT) && (!out_valid || out_ready);
  assign erase_inc = erase_cursor + 19'd1;

  // single write port: clearing pass, erase walk or program write-back
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = acc_addr;
    mem_wdata = ERASED_BYTE;
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clear_addr;
      end
      S_ERASE: begin
        mem_we = 1'b1;
        mem_waddr = acc_addr + AW'(erase_cursor);
      end
      S_RESULT: begin
        mem_we = result_go && op_prog && touch;
        mem_wdata = mem_rdata & wbyte;
      end
      S_IDLE: begin
        mem_we = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  nfa_ram #(
    .WIDTH(8),
    .DEPTH(MEM_BYTES)
  ) u_array (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_fire),
    .raddr (addr_sum[AW-1:0]),
    .rdata (mem_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      flash_size <= FLASH_SIZE_RST;
      log2_pages <= LOG2_PPB_RST;
      page_bytes <= PAGE_BYTES_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FLASH_SIZE: flash_size <= cfg_data;
        REG_LOG2_PPB:   log2_pages <= cfg_data[3:0];
        REG_PAGE_BYTES: page_bytes <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clear_addr <= '0;
      erase_cursor <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clear_addr <= clear_addr + AW'(1);
          if (clear_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            if (is_erase && !bad) begin
              erase_cursor <= '0;
            end
            if (is_erase && !bad && (nbytes != '0)) begin
              state <= S_ERASE;
            end else begin
              state <= S_RESULT;
            end
          end
        end
        S_ERASE: begin
          erase_cursor <= erase_inc;
          if (erase_inc == erase_len) begin
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (result_go) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // transaction payload latched at accept
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_read <= (action == ACT_READ);
      op_prog <= (action == ACT_PROG);
      touch <= in_touch;
      res_status <= bad && (is_rw || is_erase);
      wbyte <= write_byte;
      acc_addr <= addr_sum[AW-1:0];
      erase_len <= nbytes[18:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_go) begin
      status <= res_status;
      read_byte <= (op_read && touch) ? mem_rdata : 8'h00;
    end
  end

  `NFA_ASSERT_NEXT(a_result_lands, result_go, out_valid && (state == S_IDLE), "result lost")
  `NFA_ASSERT_NOW(a_erase_in_block, state == S_ERASE, erase_cursor < erase_len, "erase overrun")
  `NFA_ASSERT_NOW(a_no_write_idle, state == S_IDLE, !mem_we, "array written while idle")

endmodule

### design/nfa_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module nfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
